// ===== rtl/oscillation_extremum_tracker_unit_defines.svh =====
// ----------------------------------------------------------------------------
// oscillation extremum tracker - assertion macros
// concurrent assertion forms used by the tracker datapath
// ----------------------------------------------------------------------------
`ifndef OSCILLATION_EXTREMUM_TRACKER_UNIT_DEFINES_SVH
`define OSCILLATION_EXTREMUM_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication
`define OET_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("oet same-cycle check failed");

// next-cycle implication
`define OET_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("oet next-cycle check failed");

`endif

// ===== rtl/oet_pkg.sv =====
// ----------------------------------------------------------------------------
// oet_pkg
// types and constants shared by the oscillation extremum tracker
// ----------------------------------------------------------------------------
`default_nettype none

package oet_pkg;

  localparam int OUT_BITS  = 16;
  localparam int CFG_BITS  = 16;
  localparam int CNT_BITS  = 4;

  localparam logic [CFG_BITS-1:0] SETTLE_RESET = 16'd500;
  localparam logic [OUT_BITS-1:0] PERIOD_RESET = 16'd10000;
  localparam logic [CNT_BITS-1:0] LAST_STEP    = 4'(OUT_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MULT,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } oet_state_t;

  typedef struct packed {
    logic load_in;
    logic update;
    logic mult;
    logic check;
    logic div_step;
    logic load_out;
  } oet_cmd_t;

  typedef struct packed {
    logic early_done;
    logic out_busy;
  } oet_stat_t;

endpackage

`default_nettype wire

// ===== rtl/oet_in_if.sv =====
// ----------------------------------------------------------------------------
// oet_in_if
// sample channel: valid/ready with pitch and timestamp payload
// ----------------------------------------------------------------------------
`default_nettype none

interface oet_in_if #(
  parameter int ANGLE_BITS = 16,
  parameter int STAMP_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] pitch_angle;
  logic        [STAMP_BITS-1:0] time_ms;

  modport source (output valid, output pitch_angle, output time_ms, input ready);
  modport sink   (input valid, input pitch_angle, input time_ms, output ready);
endinterface

`default_nettype wire

// ===== rtl/oet_out_if.sv =====
// ----------------------------------------------------------------------------
// oet_out_if
// result channel: valid/ready with prediction and period payload
// ----------------------------------------------------------------------------
`default_nettype none

interface oet_out_if;
  logic                          valid;
  logic                          ready;
  logic [oet_pkg::OUT_BITS-1:0]  time_to_max_ms;
  logic                          prediction_valid;
  logic [oet_pkg::OUT_BITS-1:0]  period_ms;
  logic                          seeking_minimum;

  modport source (output valid, output time_to_max_ms, output prediction_valid,
                  output period_ms, output seeking_minimum, input ready);
  modport sink   (input valid, input time_to_max_ms, input prediction_valid,
                  input period_ms, input seeking_minimum, output ready);
endinterface

`default_nettype wire

// ===== rtl/oet_datapath.sv =====
// ----------------------------------------------------------------------------
// oet_datapath
// extremum tracking state, period update, prediction multiply and
// restoring divider, settle register and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "oscillation_extremum_tracker_unit_defines.svh"

module oet_datapath #(
  parameter int ANGLE_BITS = 16,
  parameter int STAMP_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire oet_pkg::oet_cmd_t              cmd,
  output oet_pkg::oet_stat_t                  stat,
  input  wire logic                           cfg_we,
  input  wire logic [oet_pkg::CFG_BITS-1:0]   cfg_data,
  input  wire logic signed [ANGLE_BITS-1:0]   in_pitch,
  input  wire logic [STAMP_BITS-1:0]          in_time,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [oet_pkg::OUT_BITS-1:0]        out_ttm,
  output logic                                out_pv,
  output logic [oet_pkg::OUT_BITS-1:0]        out_per,
  output logic                                out_seek
);

  localparam int AW = ANGLE_BITS;
  localparam int SW = STAMP_BITS;
  localparam int OB = oet_pkg::OUT_BITS;
  localparam int NW = AW + 2;
  localparam int UW = AW + 1 + OB;

  // tracker state
  logic [oet_pkg::CFG_BITS-1:0] settle;
  logic                         seek_min;
  logic signed [AW-1:0]         run_ext;
  logic [SW-1:0]                min_time;
  logic [SW-1:0]                max_time;
  logic                         min_seen;
  logic                         max_seen;
  logic signed [AW-1:0]         last_min;
  logic signed [AW-1:0]         last_max;
  logic [OB-1:0]                period;

  // per-transaction work registers
  logic signed [AW-1:0] x_r;
  logic [SW-1:0]        now_r;
  logic [UW-1:0]        prod;
  logic [AW:0]          udr;
  logic                 neg_r;
  logic                 valid_r;
  logic [UW-1:0]        rem;
  logic [UW-1:0]        dv;
  logic [OB-1:0]        quo;

  // update step
  logic [SW-1:0] t_self;
  logic [SW-1:0] t_opp;
  logic [SW-1:0] dt_self;
  logic [SW-1:0] dt_opp;
  logic [SW-1:0] gap;
  logic [SW+1:0] dt3;
  logic          third_ok;
  logic          settle_ok;
  logic          new_ext;
  logic [OB-1:0] gap_period;

  assign t_self   = seek_min ? min_time : max_time;
  assign t_opp    = seek_min ? max_time : min_time;
  assign dt_self  = now_r - t_self;
  assign dt_opp   = now_r - t_opp;
  assign gap      = t_self - t_opp;
  assign dt3      = {1'b0, dt_opp, 1'b0} + {2'b00, dt_opp};
  assign third_ok  = dt3 >= (SW+2)'(period);
  assign settle_ok = dt_self >= SW'(settle);
  assign new_ext   = seek_min ? (x_r < run_ext) : (x_r > run_ext);
  assign gap_period = (|gap[SW-1:OB-1]) ? {OB{1'b1}} : {gap[OB-2:0], 1'b0};

  // prediction operands
  logic [AW:0]   d_w;
  logic [AW:0]   d_mag;
  logic [NW-1:0] n_w;
  logic [NW-1:0] n_mag;
  logic [UW-1:0] prod_c;
  logic          valid_c;

  assign d_w = {last_max[AW-1], last_max} - {last_min[AW-1], last_min};
  assign d_mag = d_w[AW] ? (~d_w + 1'b1) : d_w;
  always_comb begin
    if (seek_min) begin
      n_w = {{2{last_max[AW-1]}}, last_max} - {last_min[AW-1], last_min, 1'b0}
            + {{2{x_r[AW-1]}}, x_r};
    end else begin
      n_w = {{2{last_max[AW-1]}}, last_max} - {{2{x_r[AW-1]}}, x_r};
    end
  end
  assign n_mag   = n_w[NW-1] ? (~n_w + 1'b1) : n_w;
  assign prod_c  = n_mag[AW:0] * period;
  assign valid_c = min_seen && max_seen && (last_max != last_min);

  // divider
  logic ovf;
  logic fits;

  assign ovf  = prod >= {udr, {OB{1'b0}}};
  assign fits = rem >= dv;

  assign stat.early_done = !valid_r || neg_r || ovf;
  assign stat.out_busy   = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle   <= oet_pkg::SETTLE_RESET;
      seek_min <= 1'b1;
      run_ext  <= '0;
      min_time <= '0;
      max_time <= '0;
      min_seen <= 1'b0;
      max_seen <= 1'b0;
      last_min <= '0;
      last_max <= '0;
      period   <= oet_pkg::PERIOD_RESET;
    end else begin
      if (cfg_we) begin
        settle <= cfg_data;
      end
      if (cmd.update) begin
        if (new_ext) begin
          run_ext <= x_r;
          if (seek_min) begin
            min_time <= now_r;
            min_seen <= 1'b1;
          end else begin
            max_time <= now_r;
            max_seen <= 1'b1;
          end
        end else if (third_ok && settle_ok) begin
          seek_min <= !seek_min;
          if (seek_min) begin
            last_min <= run_ext;
            if (max_seen) begin
              period <= gap_period;
            end
          end else begin
            last_max <= run_ext;
            if (min_seen) begin
              period <= gap_period;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r   <= in_pitch;
      now_r <= in_time;
    end
    if (cmd.mult) begin
      prod    <= prod_c;
      udr     <= {d_mag[AW-1:0], 1'b0};
      neg_r   <= n_w[NW-1] != d_w[AW];
      valid_r <= valid_c;
    end
    if (cmd.check) begin
      rem <= prod;
      dv  <= {1'b0, udr, {(OB-1){1'b0}}};
      if (!valid_r || neg_r) begin
        quo <= '0;
      end else if (ovf) begin
        quo <= '1;
      end else begin
        quo <= '0;
      end
    end
    if (cmd.div_step) begin
      if (fits) begin
        rem <= rem - dv;
      end
      quo <= {quo[OB-2:0], fits};
      dv  <= dv >> 1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ttm  <= quo;
      out_pv   <= valid_r;
      out_per  <= period;
      out_seek <= seek_min;
    end
  end

  `OET_ASSERT_IMPLY(a_invalid_zero, clk, rst, out_valid && !out_pv, out_ttm == '0)
  `OET_ASSERT_NEXT(a_state_hold, clk, rst, !cmd.update, $stable(period) && $stable(seek_min))
  `OET_ASSERT_NEXT(a_invalid_quo, clk, rst, cmd.check && !valid_r, quo == '0)

endmodule

`default_nettype wire

// ===== rtl/oet_controller.sv =====
// ----------------------------------------------------------------------------
// oet_controller
// sequencer: accept, update, multiply, range check, divide, deliver
// ----------------------------------------------------------------------------
`default_nettype none

module oet_controller (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire oet_pkg::oet_stat_t  stat,
  output oet_pkg::oet_cmd_t        cmd
);

  oet_pkg::oet_state_t            st;
  oet_pkg::oet_state_t            st_next;
  logic [oet_pkg::CNT_BITS-1:0]   cnt;
  logic [oet_pkg::CNT_BITS-1:0]   cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= oet_pkg::ST_IDLE;
      cnt <= '0;
    end else begin
      st  <= st_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    st_next  = st;
    cnt_next = cnt;
    cmd      = '0;
    in_ready = 1'b0;
    unique case (st)
      oet_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          st_next     = oet_pkg::ST_UPDATE;
        end
      end
      oet_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        st_next    = oet_pkg::ST_MULT;
      end
      oet_pkg::ST_MULT: begin
        cmd.mult = 1'b1;
        st_next  = oet_pkg::ST_CHECK;
      end
      oet_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        cnt_next  = '0;
        st_next   = stat.early_done ? oet_pkg::ST_FINISH : oet_pkg::ST_DIV;
      end
      oet_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == oet_pkg::LAST_STEP) begin
          st_next = oet_pkg::ST_FINISH;
        end
      end
      oet_pkg::ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          st_next      = oet_pkg::ST_IDLE;
        end
      end
      default: begin
        st_next = oet_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/oscillation_extremum_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// oscillation_extremum_tracker_unit
// tracks pitch minima and maxima, estimates the oscillation period and
// predicts the time to the next maximum
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    pitch_angle, time_ms
//   out_ch    out   valid/ready    time_to_max_ms, prediction_valid,
//                                  period_ms, seeking_minimum
//   cfg       in    cfg_we         cfg_data -> settle_ms
//
// each transaction runs through the 16-step restoring divider, which is skipped
// when the prediction is invalid, negative or saturated
// the result register lets the next sample be taken while a result waits
// a held result stalls the sequencer in its last step only
// rst is synchronous; settle_ms returns to 500 and period to 10000
// ----------------------------------------------------------------------------
`default_nettype none

module oscillation_extremum_tracker_unit #(
  parameter int ANGLE_BITS = 16,
  parameter int STAMP_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  oet_in_if.sink                             in_ch,
  oet_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [oet_pkg::CFG_BITS-1:0]  cfg_data
);

  oet_pkg::oet_cmd_t  cmd;
  oet_pkg::oet_stat_t stat;

  logic                        ready_w;
  logic                        out_valid_w;
  logic [oet_pkg::OUT_BITS-1:0] ttm_w;
  logic                        pv_w;
  logic [oet_pkg::OUT_BITS-1:0] per_w;
  logic                        seek_w;

  oet_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (ready_w),
    .stat     (stat),
    .cmd      (cmd)
  );

  oet_datapath #(
    .ANGLE_BITS (ANGLE_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_pitch  (in_ch.pitch_angle),
    .in_time   (in_ch.time_ms),
    .out_valid (out_valid_w),
    .out_ready (out_ch.ready),
    .out_ttm   (ttm_w),
    .out_pv    (pv_w),
    .out_per   (per_w),
    .out_seek  (seek_w)
  );

  assign in_ch.ready             = ready_w;
  assign out_ch.valid            = out_valid_w;
  assign out_ch.time_to_max_ms   = ttm_w;
  assign out_ch.prediction_valid = pv_w;
  assign out_ch.period_ms        = per_w;
  assign out_ch.seeking_minimum  = seek_w;

endmodule

`default_nettype wire
